// ===== sv/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_W = 32;
	localparam int PAY_W = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored entry as it moves between cells
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// per-word control broadcast to every cell
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// one slot of the sorted chain: holds an entry and trades it with its neighbors
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  entry_t     above,
	input  logic       above_ge,
	input  entry_t     below,
	output entry_t     cur,
	output logic       ge,
	output entry_t     nxt
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;

	assign cur = '{valid: valid_q, key: key_q, payload: payload_q};

	// this entry stays in place on a push when its key is not below the new one
	assign ge = valid_q && (key_q >= ctrl.key);

	// next content: shift toward the top on pop, keep, insert or shift away on push
	always_comb begin
		nxt = cur;
		if (ctrl.pop) begin
			nxt = below;
		end else if (ctrl.push) begin
			if (ge) begin
				nxt = cur;
			end else if (above_ge) begin
				nxt = '{valid: 1'b1, key: ctrl.key, payload: ctrl.payload};
			end else begin
				nxt = above;
			end
		end
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push || ctrl.pop) begin
			valid_q <= nxt.valid;
		end
	end

	// entry data
	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.pop) begin
			key_q     <= nxt.key;
			payload_q <= nxt.payload;
		end
	end

endmodule

// ===== sv/sorted_priority_queue_core.sv =====
// sorted priority queue: a chain of cells with the largest key in the first cell
// latency: a result word is valid in the cycle after its request word is accepted
// throughput: one push or pop per cycle; every cell compares against the new key in parallel
// a request is held off only while the result register is full and stalled
// reset clears the result valid, the count and the cell valid flags; entry data is not cleared
`timescale 1ns / 1ps

module sorted_priority_queue_core
	import spq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             cmd,
	input  logic [KEY_W-1:0] entry_key,
	input  logic [PAY_W-1:0] entry_payload,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [1:0]       status,
	output logic [KEY_W-1:0] popped_key,
	output logic [PAY_W-1:0] popped_payload,
	output logic [KEY_W-1:0] top_key,
	output logic [PAY_W-1:0] top_payload,
	output logic [CNT_W-1:0] occupancy,
	output logic             is_empty
);

	logic             rsp_valid_q;
	status_t          status_q;
	logic [KEY_W-1:0] popped_key_q;
	logic [PAY_W-1:0] popped_payload_q;
	logic [KEY_W-1:0] top_key_q;
	logic [PAY_W-1:0] top_payload_q;
	logic [CNT_W-1:0] count_q;

	logic       accept;
	logic       is_pop;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	status_t    status_d;
	logic [CNT_W-1:0] count_d;

	entry_t           cur_e [DEPTH];
	entry_t           nxt_e [DEPTH];
	logic [DEPTH-1:0] ge_v;
	logic [DEPTH-1:0] valid_v;

	// handshake: take a word unless the result register is full and stalled
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_pop = (cmd_t'(cmd) == CMD_POP);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// decode the request into cell control and status
	always_comb begin
		ctrl.push    = accept && !is_pop && !full;
		ctrl.pop     = accept && is_pop && !empty;
		ctrl.key     = entry_key;
		ctrl.payload = entry_payload;
		status_d     = ST_OK;
		if (is_pop && empty) begin
			status_d = ST_EMPTY;
		end else if (!is_pop && full) begin
			status_d = ST_FULL;
		end
		count_d = count_q;
		if (ctrl.push) begin
			count_d = count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_d = count_q - 1'b1;
		end
	end

	// chain of cells, cell 0 holds the top entry
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t above_e;
		entry_t below_e;
		logic   above_ge;

		if (i == 0) begin : g_first
			assign above_e  = '0;
			assign above_ge = 1'b1;
		end else begin : g_mid
			assign above_e  = cur_e[i-1];
			assign above_ge = ge_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign below_e = '0;
		end else begin : g_inner
			assign below_e = cur_e[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.above    (above_e),
			.above_ge (above_ge),
			.below    (below_e),
			.cur      (cur_e[i]),
			.ge       (ge_v[i]),
			.nxt      (nxt_e[i])
		);

		assign valid_v[i] = cur_e[i].valid;
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result word, top taken from the first cell's next content
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q         <= status_d;
			popped_key_q     <= ctrl.pop ? cur_e[0].key : '0;
			popped_payload_q <= ctrl.pop ? cur_e[0].payload : '0;
			top_key_q        <= nxt_e[0].valid ? nxt_e[0].key : '0;
			top_payload_q    <= nxt_e[0].valid ? nxt_e[0].payload : '0;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign popped_key     = popped_key_q;
	assign popped_payload = popped_payload_q;
	assign top_key        = top_key_q;
	assign top_payload    = top_payload_q;
	assign occupancy      = count_q;
	assign is_empty       = empty;

`ifndef SYNTHESIS
	// count matches the number of occupied cells
	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_v)))
		else $error("entry count disagrees with occupied cells");

	// occupied cells form an unbroken run from the top
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_v} + (DEPTH + 1)'(1)))
		else $error("occupied cells are not contiguous");

	// the top two keys are in order: the first cell's key is not below the second's
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_v[1] || (cur_e[0].key >= cur_e[1].key))
		else $error("top two cells out of order");

	// a push into a full queue is reported and leaves the count alone
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_pop && full) |=> (status_q == ST_FULL) && (count_q == $past(count_q)))
		else $error("push on full queue not dropped");

	// a pop on an empty queue is reported as such
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pop && empty) |=> (status_q == ST_EMPTY) && rsp_valid_q)
		else $error("pop on empty queue not reported");
`endif

endmodule

// ===== verif/tb_sorted_priority_queue_core.sv =====
// testbench for the sorted priority queue core: directed and random push/pop words
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core
	import spq_pkg::*;
();

	// one expected result word
	typedef struct {
		status_t          st;
		logic [KEY_W-1:0] popped_k;
		logic [PAY_W-1:0] popped_p;
		logic [KEY_W-1:0] top_k;
		logic [PAY_W-1:0] top_p;
		logic [CNT_W-1:0] occ;
		logic             emp;
	} queue_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	logic             cmd = 1'b0;
	logic [KEY_W-1:0] entry_key = '0;
	logic [PAY_W-1:0] entry_payload = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	logic [1:0]       status;
	logic [KEY_W-1:0] popped_key;
	logic [PAY_W-1:0] popped_payload;
	logic [KEY_W-1:0] top_key;
	logic [PAY_W-1:0] top_payload;
	logic [CNT_W-1:0] occupancy;
	logic             is_empty;

	// shadow copy of the queue contents, ascending keys, top at count-1
	logic [KEY_W-1:0] shadow_keys [DEPTH];
	logic [PAY_W-1:0] shadow_pays [DEPTH];
	int               shadow_count = 0;

	queue_result_t    pending_results [$];
	int               error_count = 0;
	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;

	sorted_priority_queue_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.cmd            (cmd),
		.entry_key      (entry_key),
		.entry_payload  (entry_payload),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.popped_key     (popped_key),
		.popped_payload (popped_payload),
		.top_key        (top_key),
		.top_payload    (top_payload),
		.occupancy      (occupancy),
		.is_empty       (is_empty)
	);

	always #10 clk = ~clk;

	// apply one push or pop to the shadow queue and return the word it should produce
	function automatic queue_result_t apply_queue_op(cmd_t op, logic [KEY_W-1:0] key,
			logic [PAY_W-1:0] pay);
		queue_result_t r;
		int pos;
		r.st       = ST_OK;
		r.popped_k = '0;
		r.popped_p = '0;
		r.top_k    = '0;
		r.top_p    = '0;
		pos = 0;
		if (op == CMD_PUSH) begin
			if (shadow_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				// insert below the first entry whose key is greater or equal
				while (pos < shadow_count && shadow_keys[pos] < key)
					pos++;
				for (int i = shadow_count; i > pos; i--) begin
					shadow_keys[i] = shadow_keys[i-1];
					shadow_pays[i] = shadow_pays[i-1];
				end
				shadow_keys[pos] = key;
				shadow_pays[pos] = pay;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.st = ST_EMPTY;
		end else begin
			shadow_count--;
			r.popped_k = shadow_keys[shadow_count];
			r.popped_p = shadow_pays[shadow_count];
		end
		if (shadow_count > 0) begin
			r.top_k = shadow_keys[shadow_count-1];
			r.top_p = shadow_pays[shadow_count-1];
		end
		r.occ = CNT_W'(shadow_count);
		r.emp = (shadow_count == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [KEY_W-1:0] want,
			logic [KEY_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// send one request word, record its expected result, then maybe idle
	task automatic send_word(input cmd_t op, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay);
		req_valid     <= 1'b1;
		cmd           <= op;
		entry_key     <= key;
		entry_payload <= pay;
		do @(posedge clk); while (req_stall);
		pending_results.push_back(apply_queue_op(op, key, pay));
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// hold off requests until every outstanding result word is back
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic test_empty_pop();
		send_word(CMD_POP, '1, '1);
		send_word(CMD_POP, '0, '0);
	endtask

	task automatic test_key_extremes();
		send_word(CMD_PUSH, '0, '0);
		send_word(CMD_PUSH, '1, '1);
		send_word(CMD_PUSH, 32'h8000_0000, 16'h5555);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_POP, '0, '0);
		send_word(CMD_POP, '0, '0);
	endtask

	// equal keys must come out oldest first
	task automatic test_equal_keys();
		send_word(CMD_PUSH, 32'd7, 16'h000a);
		send_word(CMD_PUSH, 32'd7, 16'h000b);
		send_word(CMD_PUSH, 32'd3, 16'h000d);
		send_word(CMD_PUSH, 32'd7, 16'h000c);
		send_word(CMD_PUSH, 32'd9, 16'h000e);
		repeat (5) send_word(CMD_POP, $urandom(), 16'($urandom()));
		wait_for_drain();
	endtask

	// fill to the top, push twice into the full queue, then pop one entry
	task automatic test_full_queue();
		for (int i = 0; i < DEPTH; i++)
			send_word(CMD_PUSH, $urandom_range(20), 16'(i));
		send_word(CMD_PUSH, '1, '1);
		send_word(CMD_PUSH, '0, 16'h1234);
		send_word(CMD_POP, '0, '0);
		wait_for_drain();
	endtask

	// random traffic in chunks that lean towards push, pop or neither
	task automatic test_random_traffic(input int n_words);
		int push_pct;
		logic [KEY_W-1:0] key;
		cmd_t op;
		push_pct = 50;
		for (int i = 0; i < n_words; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
			end
			if (i % 100 == 99)
				wait_for_drain();
			op = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
			case ($urandom_range(3))
				0: key = $urandom_range(7);
				1: key = $urandom_range(1) ? '1 : '0;
				default: key = $urandom();
			endcase
			send_word(op, key, 16'($urandom()));
		end
	endtask

	// receiver stall pattern
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual status %h",
					$time, status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.st, status);
				check_field("popped_key", want.popped_k, popped_key);
				check_field("popped_payload", want.popped_p, popped_payload);
				check_field("top_key", want.top_k, top_key);
				check_field("top_payload", want.top_p, top_payload);
				check_field("occupancy", want.occ, occupancy);
				check_field("is_empty", want.emp, is_empty);
			end
		end
	end

	initial begin
		send_idle_pct = 11;
		recv_idle_pct = 78;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_pop();
		test_key_extremes();
		test_equal_keys();
		test_full_queue();
		test_random_traffic(280);
		send_idle_pct = 78;
		recv_idle_pct = 11;
		test_random_traffic(280);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(290);
		wait_for_drain();
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
